FILE: rtl/mbrt_pkg.sv
// ----------------------------------------------------------------------------
// Memory block range table package
// Shared constants, status codes and the structs passed between the cells.
// ----------------------------------------------------------------------------
`default_nettype none

package mbrt_pkg;

    localparam int ADDR_BITS    = 52;
    localparam int END_BITS     = ADDR_BITS + 1;
    localparam int BLOCKS_DEF   = 128;
    localparam int NODES_DEF    = 64;
    localparam int STAT_W       = 3;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
    localparam logic [STAT_W-1:0] STAT_WARN    = 3'd1;
    localparam logic [STAT_W-1:0] STAT_MISMTCH = 3'd2;
    localparam logic [STAT_W-1:0] STAT_OVERLAP = 3'd3;
    localparam logic [STAT_W-1:0] STAT_INTERLV = 3'd4;
    localparam logic [STAT_W-1:0] STAT_FULL    = 3'd5;
    localparam logic [STAT_W-1:0] STAT_COVERED = 3'd6;
    localparam logic [STAT_W-1:0] STAT_UNCOVER = 3'd7;

    // Broadcast control and item data, same for every cell
    typedef struct packed {
        logic                eval;
        logic                shift;
        logic                commit;
        logic                cmd;
        logic [ADDR_BITS-1:0] start_a;
        logic [END_BITS-1:0]  end_a;
        logic [END_BITS-1:0]  lo;
        logic [END_BITS-1:0]  hi;
        logic                hot;
    } t_ctl;

    // One table slot as handed to the next cell
    typedef struct packed {
        logic [ADDR_BITS-1:0] start_a;
        logic [END_BITS-1:0]  end_a;
        logic                hot;
        logic                valid;
    } t_slot;

endpackage

`default_nettype wire

FILE: rtl/mbrt_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mbrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/mbrt_cell.sv
// ----------------------------------------------------------------------------
// Range table cell
// Holds one slot, checks it against the current item, and takes part in the
// conflict scan shift and the sorted insert shift.
// ----------------------------------------------------------------------------
`default_nettype none

module mbrt_cell #(
    parameter int NW = 6
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire mbrt_pkg::t_ctl              i_ctl,
    input  wire logic [NW-1:0]               i_nd,
    input  wire mbrt_pkg::t_slot             i_prev,
    input  wire logic [NW-1:0]               i_prev_owner,
    input  wire logic                        i_prev_before,
    input  wire logic [mbrt_pkg::STAT_W-1:0] i_next_sk,
    input  wire logic [NW-1:0]               i_next_so,
    output mbrt_pkg::t_slot                  o_slot,
    output logic      [NW-1:0]               o_owner,
    output logic                             o_before,
    output logic      [mbrt_pkg::STAT_W-1:0] o_sk,
    output logic      [NW-1:0]               o_so
);

    logic [mbrt_pkg::ADDR_BITS-1:0] r_start;
    logic [mbrt_pkg::END_BITS-1:0]  r_end;
    logic [NW-1:0]                  r_owner;
    logic                           r_hot;
    logic                           r_valid;
    logic [mbrt_pkg::STAT_W-1:0]    r_sk;
    logic [NW-1:0]                  r_so;
    logic [mbrt_pkg::STAT_W-1:0]    w_kind;
    logic [mbrt_pkg::END_BITS-1:0]  w_bs;
    logic [mbrt_pkg::END_BITS-1:0]  w_ns;

    assign w_bs = {1'b0, r_start};
    assign w_ns = {1'b0, i_ctl.start_a};

    always_comb begin
        w_kind = mbrt_pkg::STAT_OK;
        if (r_valid) begin
            if (i_ctl.cmd == mbrt_pkg::CMD_QUERY) begin
                if (w_bs <= w_ns && r_end >= i_ctl.end_a && r_owner == i_nd) begin
                    w_kind = mbrt_pkg::STAT_COVERED;
                end
            end else if (w_bs != r_end) begin
                if (r_end > w_ns && w_bs < i_ctl.end_a) begin
                    if (r_owner == i_nd) begin
                        w_kind = (r_hot == i_ctl.hot) ? mbrt_pkg::STAT_WARN
                                                      : mbrt_pkg::STAT_MISMTCH;
                    end else begin
                        w_kind = mbrt_pkg::STAT_OVERLAP;
                    end
                end else if (r_owner != i_nd && w_bs >= i_ctl.lo && r_end <= i_ctl.hi) begin
                    w_kind = mbrt_pkg::STAT_INTERLV;
                end
            end
        end
    end

    // New item sorts ahead of this slot; empty slots always count as ahead
    assign o_before = r_valid ? (r_start > i_ctl.start_a ||
                                 (r_start == i_ctl.start_a && r_end > i_ctl.end_a))
                              : 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.commit) begin
            if (i_prev_before) begin
                r_valid <= i_prev.valid;
            end else if (o_before) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.commit) begin
            if (i_prev_before) begin
                r_start <= i_prev.start_a;
                r_end   <= i_prev.end_a;
                r_owner <= i_prev_owner;
                r_hot   <= i_prev.hot;
            end else if (o_before) begin
                r_start <= i_ctl.start_a;
                r_end   <= i_ctl.end_a;
                r_owner <= i_nd;
                r_hot   <= i_ctl.hot;
            end
        end
        if (i_ctl.eval) begin
            r_sk <= w_kind;
            r_so <= r_owner;
        end else if (i_ctl.shift) begin
            r_sk <= i_next_sk;
            r_so <= i_next_so;
        end
    end

    assign o_slot.start_a = r_start;
    assign o_slot.end_a   = r_end;
    assign o_slot.hot     = r_hot;
    assign o_slot.valid   = r_valid;
    assign o_owner        = r_owner;
    assign o_sk           = r_sk;
    assign o_so           = r_so;

endmodule

`default_nettype wire

FILE: rtl/memory_block_range_table.sv
// ----------------------------------------------------------------------------
// Memory block range table
// Sorted table of physical memory blocks with overlap and interleave check.
// ----------------------------------------------------------------------------
// One transaction at a time. An insert or query reads the node's range from its
// RAM, compares every slot in parallel, then runs a scan that shifts the
// per-slot results down the cell chain one slot a cycle until the first hit
// or the end of the held blocks, does the sorted shift-in on an accepted
// insert, and holds the result until it is taken. A full table goes from the
// range read straight to the result.
// Blocks are kept sorted by start then end; node ranges widen only when
// non-empty; hotplug inserts raise hotplug_top and leave node ranges alone.
// ----------------------------------------------------------------------------
`default_nettype none

module memory_block_range_table #(
    parameter int BLOCKS = mbrt_pkg::BLOCKS_DEF,
    parameter int NODES  = mbrt_pkg::NODES_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_stall,
    input  wire logic         i_cmd,
    input  wire logic [5:0]   i_node,
    input  wire logic [51:0]  i_start_addr,
    input  wire logic [51:0]  i_size,
    input  wire logic [52:0]  i_end_addr,
    input  wire logic         i_hotplug,
    output logic              o_valid,
    input  wire logic         i_stall,
    output logic      [2:0]   o_status,
    output logic      [6:0]   o_conflict_index,
    output logic      [5:0]   o_conflict_node,
    output logic      [7:0]   o_block_count,
    output logic      [52:0]  o_hotplug_top
);

    localparam int NW = $clog2(NODES);
    localparam int CW = $clog2(BLOCKS + 1);
    localparam int EB = mbrt_pkg::END_BITS;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_WIDEN  = 3'd1;
    localparam logic [2:0] S_EVAL   = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_COMMIT = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    logic [2:0]                r_state, n_state;
    logic                      r_cmd;
    logic [NW-1:0]             r_nd;
    logic [51:0]               r_start;
    logic [EB-1:0]             r_end;
    logic                      r_hot;
    logic [EB-1:0]             r_lo, n_lo;
    logic [EB-1:0]             r_hi, n_hi;
    logic [CW-1:0]             r_used;
    logic [CW-1:0]             r_idx;
    logic [NODES-1:0]          r_nvalid;
    logic [63:0]               r_node_mask;
    logic [EB-1:0]             r_hot_top;
    logic [2:0]                r_status, n_status;
    logic [CW-1:0]             r_cidx, n_cidx;
    logic [NW-1:0]             r_cnode, n_cnode;
    logic                      w_accept;
    logic [NW-1:0]             w_nd;
    logic [2*EB-1:0]           w_nrd;
    logic [EB-1:0]             w_nlow, w_nhigh;
    logic                      w_commit;
    logic                      w_shift;
    mbrt_pkg::t_ctl            w_ctl;

    mbrt_pkg::t_slot           w_slot   [BLOCKS];
    logic [NW-1:0]             w_owner  [BLOCKS];
    logic [BLOCKS-1:0]         w_before;
    logic [BLOCKS-1:0]         w_valid;
    logic [2:0]                w_sk     [BLOCKS];
    logic [NW-1:0]             w_so     [BLOCKS];
    logic [CW+7:0]             w_cidx_x;
    logic [NW+7:0]             w_cnode_x;
    logic [CW+7:0]             w_used_x;

    assign w_accept = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = (r_state == S_OUT);

    // Reduce the node number into the node range
    always_comb begin
        w_nd = '0;
        for (int v = 0; v < 64; v++) begin
            if (i_node == 6'(v)) begin
                w_nd = NW'(v % NODES);
            end
        end
    end

    // Node range store: low in the upper half, high in the lower half
    mbrt_ram #(
        .WIDTH(2 * EB),
        .DEPTH(NODES)
    ) u_node_ram (
        .i_clk  (i_clk),
        .i_we   (w_commit && !r_hot),
        .i_waddr(r_nd),
        .i_wdata({r_lo, r_hi}),
        .i_raddr(w_nd),
        .o_rdata(w_nrd)
    );

    assign w_nlow  = r_nvalid[r_nd] ? w_nrd[2*EB-1:EB] : '0;
    assign w_nhigh = r_nvalid[r_nd] ? w_nrd[EB-1:0]    : '0;

    // Widen the range only when the node already has a non-empty one
    always_comb begin
        n_lo = {1'b0, r_start};
        n_hi = r_end;
        if (w_nlow != w_nhigh) begin
            if (n_lo > w_nlow) begin
                n_lo = w_nlow;
            end
            if (n_hi < w_nhigh) begin
                n_hi = w_nhigh;
            end
        end
    end

    assign w_shift  = (r_state == S_SCAN) && (r_idx != r_used) &&
                      (w_sk[0] == mbrt_pkg::STAT_OK);
    assign w_commit = (r_state == S_COMMIT);

    assign w_ctl.eval    = (r_state == S_EVAL);
    assign w_ctl.shift   = w_shift;
    assign w_ctl.commit  = w_commit;
    assign w_ctl.cmd     = r_cmd;
    assign w_ctl.start_a = r_start;
    assign w_ctl.end_a   = r_end;
    assign w_ctl.lo      = r_lo;
    assign w_ctl.hi      = r_hi;
    assign w_ctl.hot     = r_hot;

    // Cell chain: slot k takes from slot k-1 on insert, scan results flow down
    for (genvar k = 0; k < BLOCKS; k++) begin : g_cell
        if (k == 0) begin : g_head
            mbrt_cell #(.NW(NW)) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_nd         (r_nd),
                .i_prev       ('0),
                .i_prev_owner ('0),
                .i_prev_before(1'b0),
                .i_next_sk    (w_sk[k+1]),
                .i_next_so    (w_so[k+1]),
                .o_slot       (w_slot[k]),
                .o_owner      (w_owner[k]),
                .o_before     (w_before[k]),
                .o_sk         (w_sk[k]),
                .o_so         (w_so[k])
            );
        end else if (k == BLOCKS - 1) begin : g_tail
            mbrt_cell #(.NW(NW)) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_nd         (r_nd),
                .i_prev       (w_slot[k-1]),
                .i_prev_owner (w_owner[k-1]),
                .i_prev_before(w_before[k-1]),
                .i_next_sk    (mbrt_pkg::STAT_OK),
                .i_next_so    ('0),
                .o_slot       (w_slot[k]),
                .o_owner      (w_owner[k]),
                .o_before     (w_before[k]),
                .o_sk         (w_sk[k]),
                .o_so         (w_so[k])
            );
        end else begin : g_mid
            mbrt_cell #(.NW(NW)) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_nd         (r_nd),
                .i_prev       (w_slot[k-1]),
                .i_prev_owner (w_owner[k-1]),
                .i_prev_before(w_before[k-1]),
                .i_next_sk    (w_sk[k+1]),
                .i_next_so    (w_so[k+1]),
                .o_slot       (w_slot[k]),
                .o_owner      (w_owner[k]),
                .o_before     (w_before[k]),
                .o_sk         (w_sk[k]),
                .o_so         (w_so[k])
            );
        end
        assign w_valid[k] = w_slot[k].valid;
    end

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        n_cidx   = r_cidx;
        n_cnode  = r_cnode;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_WIDEN;
                end
            end
            S_WIDEN: begin
                if (r_cmd == mbrt_pkg::CMD_INSERT && r_used >= CW'(BLOCKS)) begin
                    n_status = mbrt_pkg::STAT_FULL;
                    n_cidx   = '0;
                    n_cnode  = '0;
                    n_state  = S_OUT;
                end else begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_idx == r_used) begin
                    // no hit among the held blocks
                    n_cidx  = '0;
                    n_cnode = '0;
                    if (r_cmd == mbrt_pkg::CMD_QUERY) begin
                        n_status = mbrt_pkg::STAT_UNCOVER;
                        n_state  = S_OUT;
                    end else begin
                        n_status = mbrt_pkg::STAT_OK;
                        n_state  = S_COMMIT;
                    end
                end else if (w_sk[0] != mbrt_pkg::STAT_OK) begin
                    n_status = w_sk[0];
                    if (r_cmd == mbrt_pkg::CMD_QUERY) begin
                        n_cidx  = '0;
                        n_cnode = '0;
                        n_state = S_OUT;
                    end else begin
                        n_cidx  = r_idx;
                        n_cnode = w_so[0];
                        n_state = (w_sk[0] == mbrt_pkg::STAT_WARN) ? S_COMMIT : S_OUT;
                    end
                end
            end
            S_COMMIT: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_nvalid    <= '0;
            r_node_mask <= '0;
            r_hot_top   <= '0;
            r_idx       <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_EVAL) begin
                r_idx <= '0;
            end else if (w_shift) begin
                r_idx <= r_idx + 1'b1;
            end
            if (w_commit) begin
                r_used <= r_used + 1'b1;
                if (!r_hot) begin
                    r_nvalid[r_nd] <= 1'b1;
                    r_node_mask    <= r_node_mask | (64'd1 << r_nd);
                end else if (r_end > r_hot_top) begin
                    r_hot_top <= r_end;
                end
            end
        end
    end

    // Item and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= i_cmd;
            r_nd    <= w_nd;
            r_start <= i_start_addr;
            r_hot   <= i_hotplug;
            r_end   <= (i_cmd == mbrt_pkg::CMD_QUERY) ? i_end_addr
                     : ({1'b0, i_start_addr} + {1'b0, i_size});
        end
        if (r_state == S_WIDEN) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
        r_status <= n_status;
        r_cidx   <= n_cidx;
        r_cnode  <= n_cnode;
    end

    assign w_cidx_x  = {8'd0, r_cidx};
    assign w_cnode_x = {8'd0, r_cnode};
    assign w_used_x  = {8'd0, r_used};

    assign o_status         = r_status;
    assign o_conflict_index = w_cidx_x[6:0];
    assign o_conflict_node  = w_cnode_x[5:0];
    assign o_block_count    = w_used_x[7:0];
    assign o_hotplug_top    = r_hot_top;

`ifndef NO_ASSERTIONS
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(BLOCKS))
        else $error("block count beyond table depth");

    a_valid_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_used))
        else $error("cell valid bits disagree with block count");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx <= r_used))
        else $error("scan ran past held blocks");

    a_commit_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT) |=> (r_used == $past(r_used) + 1'b1))
        else $error("insert did not grow the table");
`endif

endmodule

`default_nettype wire
